### hw/rtl/stt_pkg.sv
`default_nettype none
package stt_pkg;

   localparam int KEY_BITS      = 64;
   localparam int DEPTH_BITS    = 7;
   localparam int SCORE_BITS    = 16;
   localparam int PLY_BITS      = 8;
   localparam int MOVE_BITS     = 16;
   localparam int THRESH_BITS   = 15;
   localparam int EXT_BITS      = SCORE_BITS + 2;
   localparam int TABLE_ENTRIES_DEFAULT = 4096;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(30000);

   localparam logic signed [EXT_BITS-1:0] SAT_HI = EXT_BITS'((1 << (SCORE_BITS - 1)) - 1);
   localparam logic signed [EXT_BITS-1:0] SAT_LO = ~SAT_HI;

   typedef enum logic [1:0] {
      REQ_PROBE = 2'd0,
      REQ_STORE = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_EXACT = 2'd0,
      KIND_UPPER = 2'd1,
      KIND_LOWER = 2'd2,
      KIND_NONE  = 2'd3
   } bound_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CLEAR,
      ST_REPLY
   } back_state_type;

   typedef struct packed {
      logic [1:0]                    req_type;
      logic [KEY_BITS-1:0]           position_key;
      logic [DEPTH_BITS-1:0]         search_depth;
      logic signed [SCORE_BITS-1:0]  alpha_bound;
      logic signed [SCORE_BITS-1:0]  beta_bound;
      logic [PLY_BITS-1:0]           ply_from_root;
      logic signed [SCORE_BITS-1:0]  store_score;
      logic [1:0]                    bound_kind;
      logic [MOVE_BITS-1:0]          move_in;
   } stt_req_type;

   typedef struct packed {
      logic                          cutoff;
      logic signed [SCORE_BITS-1:0]  score_out;
      logic                          move_found;
      logic [MOVE_BITS-1:0]          move_out;
   } stt_rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]           tag;
      logic [DEPTH_BITS-1:0]         depth;
      logic signed [SCORE_BITS-1:0]  score;
      logic [1:0]                    kind;
      logic [MOVE_BITS-1:0]          move;
   } stt_entry_type;

   localparam int ENTRY_BITS = $bits(stt_entry_type);

   localparam stt_entry_type EMPTY_ENTRY = '{
      tag: '0, depth: '0, score: '0, kind: KIND_NONE, move: '0
   };

   // classified request as it waits between front and back
   typedef struct packed {
      req_kind_type                  code;
      logic [KEY_BITS-1:0]           key;
      logic [DEPTH_BITS-1:0]         depth;
      logic signed [SCORE_BITS-1:0]  alpha;
      logic signed [SCORE_BITS-1:0]  beta;
      logic [PLY_BITS-1:0]           ply;
      logic signed [SCORE_BITS-1:0]  root_score;
      logic [1:0]                    kind;
      logic [MOVE_BITS-1:0]          move;
   } stt_op_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } stt_back_status_type;

   // to_root: store direction (root-relative); otherwise node-relative
   function automatic logic signed [SCORE_BITS-1:0] mate_adjust(
      input logic signed [SCORE_BITS-1:0] s,
      input logic [PLY_BITS-1:0]          ply,
      input logic [THRESH_BITS-1:0]       thr,
      input logic                         to_root
   );
      logic signed [EXT_BITS-1:0] se;
      logic signed [EXT_BITS-1:0] pe;
      logic signed [EXT_BITS-1:0] te;
      logic signed [EXT_BITS-1:0] sum;
      logic signed [SCORE_BITS-1:0] res;
      se  = {{(EXT_BITS-SCORE_BITS){s[SCORE_BITS-1]}}, s};
      pe  = {{(EXT_BITS-PLY_BITS){1'b0}}, ply};
      te  = {{(EXT_BITS-THRESH_BITS){1'b0}}, thr};
      sum = se;
      if (se > te) begin
         sum = to_root ? se + pe : se - pe;
      end else if (se < -te) begin
         sum = to_root ? se - pe : se + pe;
      end
      if (sum > SAT_HI) begin
         res = SAT_HI[SCORE_BITS-1:0];
      end else if (sum < SAT_LO) begin
         res = SAT_LO[SCORE_BITS-1:0];
      end else begin
         res = sum[SCORE_BITS-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/stt_ram.sv
`default_nettype none
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     wr_en,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/stt_front.sv
`default_nettype none
module stt_front import stt_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   input  wire stt_req_type              req_data,
   output logic                          req_full,
   input  wire logic                     csr_wr_en,
   input  wire logic [THRESH_BITS-1:0]   csr_wr_data,
   input  wire stt_back_status_type      back_status,
   output logic                          head_valid,
   output stt_op_type                    head_op,
   output logic [THRESH_BITS-1:0]        threshold
);

   stt_op_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic [THRESH_BITS-1:0] thr_ff;
   stt_op_type             op_in;
   logic                   push;
   logic                   pop;

   assign req_full   = (count_ff == QCNT_BITS'(QUEUE_DEPTH)) | back_status.init_busy;
   assign push       = req_push & ~req_full;
   assign pop        = back_status.pop;
   assign head_valid = (count_ff != '0);
   assign head_op    = q_ff[rd_ptr_ff];
   assign threshold  = thr_ff;

   // classify, and make the store score root-relative on the way in
   always_comb begin
      op_in.code       = req_kind_type'(req_data.req_type);
      op_in.key        = req_data.position_key;
      op_in.depth      = req_data.search_depth;
      op_in.alpha      = req_data.alpha_bound;
      op_in.beta       = req_data.beta_bound;
      op_in.ply        = req_data.ply_from_root;
      op_in.root_score = mate_adjust(req_data.store_score, req_data.ply_from_root,
                                     thr_ff, 1'b1);
      op_in.kind       = req_data.bound_kind;
      op_in.move       = req_data.move_in;
   end

   always_comb begin
      wr_ptr_in = push ? QPTR_BITS'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_BITS'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         thr_ff    <= THRESH_RESET;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/stt_back.sv
`default_nettype none
module stt_back import stt_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   localparam int SLOT_BITS    = $clog2(TABLE_ENTRIES)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire stt_op_type              head_op,
   input  wire logic [THRESH_BITS-1:0]  threshold,
   output stt_back_status_type          back_status,
   output logic [SLOT_BITS-1:0]         ram_addr,
   output logic                         ram_wr_en,
   output logic [ENTRY_BITS-1:0]        ram_wr_data,
   output logic                         ram_rd_en,
   input  wire logic [ENTRY_BITS-1:0]   ram_rd_data,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output stt_rsp_type                  rsp_data
);

   back_state_type           state_ff, state_in;
   stt_op_type               op_ff, op_in;
   logic [SLOT_BITS-1:0]     ptr_ff, ptr_in;
   logic                     init_ff, init_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   stt_rsp_type              rsp_ff;
   stt_rsp_type              rsp_new;
   logic                     rsp_push;
   logic                     rsp_free;
   logic                     pop;
   stt_entry_type            cur;
   stt_entry_type            new_entry;
   stt_rsp_type              probe_rsp;
   logic signed [SCORE_BITS-1:0] node_score;
   logic                     hit;
   logic                     replace;

   assign cur      = stt_entry_type'(ram_rd_data);
   assign rsp_free = ~rsp_valid_ff | rsp_pop;

   always_comb begin
      new_entry.tag   = op_ff.key;
      new_entry.depth = op_ff.depth;
      new_entry.score = op_ff.root_score;
      new_entry.kind  = op_ff.kind;
      new_entry.move  = op_ff.move;
      replace = (cur.depth <= op_ff.depth) | (cur.tag != op_ff.key);
   end

   always_comb begin
      hit        = (cur.tag == op_ff.key) & (cur.depth >= op_ff.depth);
      node_score = mate_adjust(cur.score, op_ff.ply, threshold, 1'b0);
      probe_rsp  = '0;
      if (hit) begin
         probe_rsp.move_found = 1'b1;
         probe_rsp.move_out   = cur.move;
         case (cur.kind)
            KIND_EXACT: begin
               probe_rsp.cutoff    = 1'b1;
               probe_rsp.score_out = node_score;
            end
            KIND_UPPER: begin
               if (node_score <= op_ff.alpha) begin
                  probe_rsp.cutoff    = 1'b1;
                  probe_rsp.score_out = op_ff.alpha;
               end
            end
            KIND_LOWER: begin
               if (node_score >= op_ff.beta) begin
                  probe_rsp.cutoff    = 1'b1;
                  probe_rsp.score_out = op_ff.beta;
               end
            end
            default: begin
               probe_rsp.cutoff = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      ptr_in      = ptr_ff;
      init_in     = init_ff;
      pop         = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_addr    = op_ff.key[SLOT_BITS-1:0];
      ram_wr_data = new_entry;
      rsp_push    = 1'b0;
      rsp_new     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop   = 1'b1;
               op_in = head_op;
               if (head_op.code == REQ_CLEAR) begin
                  ptr_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  ram_rd_en = 1'b1;
                  ram_addr  = head_op.key[SLOT_BITS-1:0];
                  state_in  = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            // read data holds until the result register has room
            if (rsp_free) begin
               rsp_push = 1'b1;
               if (op_ff.code == REQ_PROBE) begin
                  rsp_new = probe_rsp;
               end
               ram_wr_en = (op_ff.code == REQ_STORE) & replace;
               state_in  = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_addr    = ptr_ff;
            ram_wr_data = EMPTY_ENTRY;
            ptr_in      = ptr_ff + SLOT_BITS'(1);
            if (ptr_ff == SLOT_BITS'(TABLE_ENTRIES - 1)) begin
               ptr_in   = '0;
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in          = rsp_push | (rsp_valid_ff & ~rsp_pop);
   assign rsp_empty             = ~rsp_valid_ff;
   assign rsp_data              = rsp_ff;
   assign back_status.pop       = pop;
   assign back_status.init_busy = init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      if (rsp_push) begin
         rsp_ff <= rsp_new;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/search_transposition_table_top.sv
`default_nettype none
// channel   ports                                  transfer when
// request   req_push, req_full, req_data           req_push & ~req_full
// response  rsp_pop, rsp_empty, rsp_data           rsp_pop & ~rsp_empty
// config    csr_wr_en, csr_wr_data                 csr_wr_en
//
// probe and store pass through the back end in order: read the slot from the single-port
// table ram, then compare, update the slot and load the result register once it has room.
// clear is dispatched, writes the empty entry into every slot, then loads its result.
// after reset a clearing pass over every slot runs with req_full held high.
// a two-entry request queue keeps accepting while a result waits for rsp_pop.
// table index is the low key bits; TABLE_ENTRIES must be a power of two, which the block does not enforce.
module search_transposition_table_top import stt_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   input  wire stt_req_type             req_data,
   output logic                         req_full,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output stt_rsp_type                  rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [THRESH_BITS-1:0]  csr_wr_data
);

   localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);

   stt_back_status_type      back_status;
   logic                     head_valid;
   stt_op_type               head_op;
   logic [THRESH_BITS-1:0]   threshold;
   logic [SLOT_BITS-1:0]     ram_addr;
   logic                     ram_wr_en;
   logic [ENTRY_BITS-1:0]    ram_wr_data;
   logic                     ram_rd_en;
   logic [ENTRY_BITS-1:0]    ram_rd_data;

   stt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .back_status (back_status),
      .head_valid  (head_valid),
      .head_op     (head_op),
      .threshold   (threshold)
   );

   stt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_op     (head_op),
      .threshold   (threshold),
      .back_status (back_status),
      .ram_addr    (ram_addr),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_data (ram_rd_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   stt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .addr    (ram_addr),
      .wr_en   (ram_wr_en),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

### bench/search_transposition_table_top_test.sv
`default_nettype none
module search_transposition_table_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import stt_pkg::*;

   localparam int SLOTS = TABLE_ENTRIES_DEFAULT;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int SCORE_MAX = (1 << (SCORE_BITS - 1)) - 1;
   localparam int SCORE_MIN = -SCORE_MAX - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   stt_req_type req_data = '0;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   stt_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [THRESH_BITS-1:0] csr_wr_data = '0;

   always #10 clock = ~clock;

   search_transposition_table_top uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // shadow copy of the table and the mate threshold register
   logic [KEY_BITS-1:0]          shadow_tag   [SLOTS];
   logic [DEPTH_BITS-1:0]        shadow_depth [SLOTS];
   logic signed [SCORE_BITS-1:0] shadow_score [SLOTS];
   bound_kind_type               shadow_kind  [SLOTS];
   logic [MOVE_BITS-1:0]         shadow_move  [SLOTS];
   logic [THRESH_BITS-1:0]       mate_limit = THRESH_RESET;

   stt_req_type request_backlog [$];
   stt_rsp_type due_replies [$];
   logic [KEY_BITS-1:0] known_keys [$];

   int gap_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int probes = 0;
   int probe_hits = 0;
   int cutoffs = 0;
   int stores = 0;
   int clears = 0;
   int limit_writes = 0;

   function automatic void wipe_shadow();
      for (int i = 0; i < SLOTS; i++) begin
         shadow_tag[i] = '0;
         shadow_depth[i] = '0;
         shadow_score[i] = '0;
         shadow_kind[i] = KIND_NONE;
         shadow_move[i] = '0;
      end
   endfunction

   // to_root: store direction; otherwise back to node-relative
   function automatic logic signed [SCORE_BITS-1:0] mate_shift(
      logic signed [SCORE_BITS-1:0] s,
      logic [PLY_BITS-1:0] ply,
      bit to_root
   );
      int v;
      int lim;
      int p;
      v = s;
      lim = mate_limit;
      p = ply;
      if (v > lim) begin
         v = to_root ? v + p : v - p;
      end else if (v < -lim) begin
         v = to_root ? v - p : v + p;
      end
      if (v > SCORE_MAX) v = SCORE_MAX;
      else if (v < SCORE_MIN) v = SCORE_MIN;
      return v[SCORE_BITS-1:0];
   endfunction

   // reply of one request, updating the shadow table on the way
   function automatic stt_rsp_type apply_request(stt_req_type r);
      stt_rsp_type rsp;
      int slot;
      logic signed [SCORE_BITS-1:0] node_score;
      rsp = '0;
      slot = int'(r.position_key % 64'(SLOTS));
      case (req_kind_type'(r.req_type))
         REQ_PROBE: begin
            probes++;
            if (shadow_tag[slot] == r.position_key && shadow_depth[slot] >= r.search_depth) begin
               node_score = mate_shift(shadow_score[slot], r.ply_from_root, 1'b0);
               rsp.move_found = 1'b1;
               rsp.move_out = shadow_move[slot];
               probe_hits++;
               case (shadow_kind[slot])
                  KIND_EXACT: begin
                     rsp.cutoff = 1'b1;
                     rsp.score_out = node_score;
                  end
                  KIND_UPPER: begin
                     if (node_score <= $signed(r.alpha_bound)) begin
                        rsp.cutoff = 1'b1;
                        rsp.score_out = r.alpha_bound;
                     end
                  end
                  KIND_LOWER: begin
                     if (node_score >= $signed(r.beta_bound)) begin
                        rsp.cutoff = 1'b1;
                        rsp.score_out = r.beta_bound;
                     end
                  end
                  default: ;
               endcase
               if (rsp.cutoff) cutoffs++;
            end
         end
         REQ_STORE: begin
            stores++;
            if (shadow_depth[slot] <= r.search_depth || shadow_tag[slot] != r.position_key) begin
               shadow_tag[slot] = r.position_key;
               shadow_depth[slot] = r.search_depth;
               shadow_score[slot] = mate_shift(r.store_score, r.ply_from_root, 1'b1);
               shadow_kind[slot] = bound_kind_type'(r.bound_kind);
               shadow_move[slot] = r.move_in;
            end
         end
         REQ_CLEAR: begin
            clears++;
            wipe_shadow();
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic stt_req_type make_request(
      req_kind_type code,
      logic [KEY_BITS-1:0] key,
      int depth,
      int alpha,
      int beta,
      int ply,
      int score,
      bound_kind_type bkind,
      int move
   );
      stt_req_type r;
      r.req_type = code;
      r.position_key = key;
      r.search_depth = depth[DEPTH_BITS-1:0];
      r.alpha_bound = alpha[SCORE_BITS-1:0];
      r.beta_bound = beta[SCORE_BITS-1:0];
      r.ply_from_root = ply[PLY_BITS-1:0];
      r.store_score = score[SCORE_BITS-1:0];
      r.bound_kind = bkind;
      r.move_in = move[MOVE_BITS-1:0];
      return r;
   endfunction

   // scores over the whole range, clustered around zero, the mate threshold and the range ends
   function automatic logic [SCORE_BITS-1:0] pick_score();
      int v;
      case ($urandom_range(5))
         0: v = int'($urandom_range(65535)) - 32768;
         1: v = int'(mate_limit) + int'($urandom_range(300)) - 150;
         2: v = -int'(mate_limit) + int'($urandom_range(300)) - 150;
         3: v = $urandom_range(1) ? SCORE_MAX : SCORE_MIN;
         default: v = int'($urandom_range(2000)) - 1000;
      endcase
      if (v > SCORE_MAX) v = SCORE_MAX;
      else if (v < SCORE_MIN) v = SCORE_MIN;
      return v[SCORE_BITS-1:0];
   endfunction

   function automatic stt_req_type random_request();
      stt_req_type r;
      int pick;
      int key_pick;
      logic [KEY_BITS-1:0] base;
      logic [KEY_BITS-1:0] fresh;
      pick = $urandom_range(999);
      if (pick < 3) r.req_type = REQ_CLEAR;
      else if (pick < 30) r.req_type = REQ_NONE;
      else if (pick < 520) r.req_type = REQ_STORE;
      else r.req_type = REQ_PROBE;
      key_pick = $urandom_range(9);
      fresh = {$urandom, $urandom};
      if (known_keys.size() == 0 || key_pick < 2) begin
         r.position_key = fresh;
      end else if (key_pick == 2) begin
         r.position_key = '0;
      end else begin
         base = known_keys[$urandom_range(known_keys.size() - 1)];
         r.position_key = base;
         // same slot, different tag
         if (key_pick >= 8) begin
            r.position_key = {fresh[KEY_BITS-1:SLOT_BITS], base[SLOT_BITS-1:0]};
         end
      end
      if (r.req_type == REQ_STORE) begin
         known_keys.push_back(r.position_key);
         if (known_keys.size() > 48) known_keys.delete(0);
      end
      r.search_depth = DEPTH_BITS'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                           : $urandom_range(12));
      r.alpha_bound = pick_score();
      r.beta_bound = pick_score();
      r.ply_from_root = PLY_BITS'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                          : $urandom_range(20));
      r.store_score = pick_score();
      r.bound_kind = ($urandom_range(9) == 0) ? KIND_NONE : bound_kind_type'($urandom_range(2));
      r.move_in = MOVE_BITS'($urandom_range(65535));
      return r;
   endfunction

   task automatic note_mismatch(string what, stt_rsp_type want, stt_rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch %0d, %s: cutoff %0b/%0b score %0d/%0d found %0b/%0b move %h/%h",
            mismatches, what, want.cutoff, got.cutoff, $signed(want.score_out),
            $signed(got.score_out), want.move_found, got.move_found, want.move_out,
            got.move_out);
      end
   endtask

   // request side: one transfer per edge with push high and full low
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            due_replies.push_back(apply_request(req_data));
            request_backlog.delete(0);
         end
         if (!req_push || !req_full) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_push <= 1'b1;
               req_data <= request_backlog[0];
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // reply side
   always @(posedge clock) begin : reply_check
      stt_rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_replies.size() == 0) begin
               note_mismatch("reply with nothing pending", '0, rsp_data);
            end else begin
               want = due_replies.pop_front();
               if (rsp_data.cutoff !== want.cutoff || rsp_data.score_out !== want.score_out
                   || rsp_data.move_found !== want.move_found
                   || rsp_data.move_out !== want.move_out) begin
                  note_mismatch("field differs (expected/actual)", want, rsp_data);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic drain();
      while (request_backlog.size() != 0 || due_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [THRESH_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mate_limit = value;
      limit_writes++;
   endtask

   task automatic run_phase(int count, logic [THRESH_BITS-1:0] limit, int gap, int stall);
      write_limit(limit);
      gap_pct = gap;
      stall_pct = stall;
      for (int i = 0; i < count; i++) request_backlog.push_back(random_request());
      drain();
   endtask

   initial begin
      logic [KEY_BITS-1:0] k_top;
      logic [KEY_BITS-1:0] k_upper;
      logic [KEY_BITS-1:0] k_lower;
      logic [KEY_BITS-1:0] k_alias;
      k_top = '1;
      k_upper = 64'h0123_4567_89ab_c123;
      k_lower = 64'hfedc_ba98_7654_3777;
      k_alias = 64'h1111_2222_3333_4777;
      wipe_shadow();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // cleared slot with key 0 at depth 0 still reports its move
      request_backlog.push_back(make_request(REQ_PROBE, '0, 0, 0, 0, 0, 0, KIND_EXACT, 0));
      // mate score at the top of the range, saturating on store
      request_backlog.push_back(make_request(REQ_STORE, k_top, 127, 0, 0, 255, SCORE_MAX,
         KIND_EXACT, 16'hffff));
      request_backlog.push_back(make_request(REQ_PROBE, k_top, 127, SCORE_MIN, SCORE_MAX, 255,
         0, KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_PROBE, k_top, 127, 0, 0, 0, 0, KIND_EXACT, 0));
      // negative mate, upper bound at or below alpha
      request_backlog.push_back(make_request(REQ_STORE, k_upper, 5, 0, 0, 10, SCORE_MIN,
         KIND_UPPER, 16'h1234));
      request_backlog.push_back(make_request(REQ_PROBE, k_upper, 5, -100, 0, 10, 0,
         KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_PROBE, k_upper, 5, SCORE_MIN, 0, 0, 0,
         KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_PROBE, k_upper, 6, 0, 0, 0, 0, KIND_EXACT, 0));
      // lower bound at beta and just below it
      request_backlog.push_back(make_request(REQ_STORE, k_lower, 10, 0, 0, 3, 500,
         KIND_LOWER, 16'habcd));
      request_backlog.push_back(make_request(REQ_PROBE, k_lower, 10, 0, 500, 0, 0,
         KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_PROBE, k_lower, 0, 0, 501, 0, 0,
         KIND_EXACT, 0));
      // shallower store to the same key keeps the deeper entry
      request_backlog.push_back(make_request(REQ_STORE, k_lower, 3, 0, 0, 0, -7,
         KIND_EXACT, 1));
      request_backlog.push_back(make_request(REQ_PROBE, k_lower, 10, 0, SCORE_MAX, 0, 0,
         KIND_EXACT, 0));
      // different tag in the same slot always replaces
      request_backlog.push_back(make_request(REQ_STORE, k_alias, 0, 0, 0, 0, 0, KIND_EXACT, 2));
      request_backlog.push_back(make_request(REQ_PROBE, k_lower, 0, 0, 0, 0, 0, KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_PROBE, k_alias, 0, 0, 0, 0, 0, KIND_EXACT, 0));
      // none kind never cuts off
      request_backlog.push_back(make_request(REQ_STORE, k_upper, 5, 0, 0, 0, 40, KIND_NONE, 3));
      request_backlog.push_back(make_request(REQ_PROBE, k_upper, 0, SCORE_MAX, SCORE_MIN, 0, 0,
         KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_NONE, k_top, 0, 0, 0, 0, 0, KIND_NONE, 0));
      request_backlog.push_back(make_request(REQ_PROBE, k_top, 127, 0, 0, 255, 0,
         KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_CLEAR, '0, 0, 0, 0, 0, 0, KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_PROBE, k_top, 0, 0, 0, 0, 0, KIND_EXACT, 0));
      request_backlog.push_back(make_request(REQ_PROBE, '0, 0, 0, 0, 0, 0, KIND_EXACT, 0));
      drain();

      run_phase(245, '0, 87, 0);
      run_phase(245, 15'h7fff, 0, 87);
      run_phase(245, 100, 8, 8);
      run_phase(245, THRESH_BITS'($urandom_range(32767)), 0, 0);
      run_phase(245, THRESH_RESET, 30, 30);

      repeat (16) @(posedge clock);
      if (due_replies.size() != 0) begin
         $display("%0d replies never arrived", due_replies.size());
         mismatches += due_replies.size();
      end
      $display("covered %0d probes (%0d hits, %0d cutoffs), %0d stores, %0d clears",
         probes, probe_hits, cutoffs, stores, clears);
      $display("across %0d mate threshold settings, including 0 and 32767", limit_writes);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire
